// File: rtl/timed_task_deadline_queue_assert.svh
// Assertion macros used by the deadline queue datapath.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef TIMED_TASK_DEADLINE_QUEUE_ASSERT_SVH
`define TIMED_TASK_DEADLINE_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TTDQ_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deadline queue check failed");

// Next-cycle implication, checked outside reset.
`define TTDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deadline queue check failed");

`endif

// File: rtl/ttdq_pkg.sv
// Shared types and constants of the deadline queue.
// No dependencies; every other RTL file but the assertion header imports this package.
package ttdq_pkg;

  localparam int TASK_W  = 6;
  localparam int TIME_W  = 62;
  localparam int OTIME_W = 63;
  localparam int COUNT_W = 5;
  localparam int OP_W    = 3;
  localparam int ST_W    = 2;
  localparam int JIT_W   = 32;

  localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [OTIME_W-1:0] TIME_NONE = {OTIME_W{1'b1}};

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SCHEDULE   = 3'd0;
  localparam logic [OP_W-1:0] OP_UNSCHEDULE = 3'd1;
  localparam logic [OP_W-1:0] OP_POP        = 3'd2;
  localparam logic [OP_W-1:0] OP_RUNNABLES  = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD     = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_CALC, S_INS_RD, S_INS_CMP, S_SCAN_RD, S_SCAN_CMP,
    S_HEAD_RD, S_HEAD_CMP, S_RUN_RD, S_RUN_CMP, S_EMIT, S_EMIT_RUN
  } state_e;

  typedef enum logic [2:0] {
    RES_BAD, RES_IGN, RES_EMPTY, RES_SCHED, RES_REMOVED, RES_RUN_ITEM,
    RES_PEEK, RES_CLOSE
  } res_e;

  typedef enum logic [1:0] {RD_DEC, RD_J, RD_ZERO} rd_sel_e;
  typedef enum logic [1:0] {WR_UP, WR_NEW, WR_DN} wr_sel_e;

  typedef struct packed {
    logic [TASK_W-1:0] tid;
    logic [TIME_W-1:0] dl;
  } ent_t;

  typedef struct packed {
    logic    in_ready;
    logic    capture;
    logic    calc;
    logic    i_dec;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    ins_done;
    logic    scan_init;
    logic    take_head;
    logic    mark_found;
    logic    j_inc;
    logic    rm_done;
    logic    run_init;
    logic    n_inc;
    logic    set_res;
    res_e    res;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic            in_valid;
    logic [OP_W-1:0] op;
    logic            id_bad;
    logic            queued;
    logic            empty;
    logic            run_bad;
    logic            i_zero;
    logic            ins_move;
    logic            j_end;
    logic            found;
    logic            id_match;
    logic            run_take;
    logic            out_free;
  } stat_t;

endpackage

// File: rtl/ttdq_in_if.sv
// Request channel of the deadline queue: valid, ready and one request beat.
// Depends on ttdq_pkg for field widths.
interface ttdq_in_if import ttdq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [TASK_W-1:0] task_id;
  logic [TIME_W-1:0] now_time;
  logic              is_first;
  logic              do_repeat;
  logic [TIME_W-1:0] interval;
  logic [TIME_W-1:0] initial_delay;
  logic [COUNT_W-1:0] max_count;

  modport source (output valid, operation, task_id, now_time, is_first, do_repeat,
                  interval, initial_delay, max_count, input ready);
  modport sink (input valid, operation, task_id, now_time, is_first, do_repeat,
                interval, initial_delay, max_count, output ready);
endinterface

// File: rtl/ttdq_out_if.sv
// Result channel of the deadline queue: valid, ready and one result beat.
// Depends on ttdq_pkg for field widths.
interface ttdq_out_if import ttdq_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [TASK_W-1:0]         result_task;
  logic                      has_task;
  logic signed [OTIME_W-1:0] time_value;
  logic [COUNT_W-1:0]        due_count;
  logic [ST_W-1:0]           status;
  logic                      last;

  modport source (output valid, result_task, has_task, time_value, due_count, status,
                  last, input ready);
  modport sink (input valid, result_task, has_task, time_value, due_count, status,
                last, output ready);
endinterface

// File: rtl/ttdq_cfg_if.sv
// Configuration write channel carrying the scheduling jitter register.
// Depends on ttdq_pkg for the data width.
interface ttdq_cfg_if import ttdq_pkg::*;;
  logic             valid;
  logic             ready;
  logic [JIT_W-1:0] sched_jitter;

  modport source (output valid, sched_jitter, input ready);
  modport sink (input valid, sched_jitter, output ready);
endinterface

// File: rtl/ttdq_ctrl.sv
// Sequencer of the deadline queue: walks insert, removal and batch loops.
// Depends on ttdq_pkg; drives the datapath through cmd_t and reads stat_t.
module ttdq_ctrl import ttdq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (stat_i.in_valid) state_d = S_CHECK;
      end
      S_CHECK: begin
        priority if (stat_i.op == OP_SCHEDULE || stat_i.op == OP_UNSCHEDULE) begin
          priority if (stat_i.id_bad) state_d = S_EMIT;
          else if (stat_i.op == OP_SCHEDULE) state_d = stat_i.queued ? S_EMIT : S_CALC;
          else state_d = stat_i.queued ? S_SCAN_RD : S_EMIT;
        end else if (stat_i.op == OP_POP || stat_i.op == OP_PEEK) begin
          state_d = stat_i.empty ? S_EMIT : S_HEAD_RD;
        end else if (stat_i.op == OP_RUNNABLES) begin
          state_d = stat_i.run_bad ? S_EMIT : S_RUN_RD;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_CALC:     state_d = S_INS_RD;
      S_INS_RD:   state_d = stat_i.i_zero ? S_EMIT : S_INS_CMP;
      S_INS_CMP:  state_d = stat_i.ins_move ? S_INS_RD : S_EMIT;
      S_SCAN_RD: begin
        if (stat_i.j_end) begin
          state_d = (stat_i.op == OP_RUNNABLES) ? S_EMIT_RUN : S_EMIT;
        end else begin
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: state_d = S_SCAN_RD;
      S_HEAD_RD:  state_d = S_HEAD_CMP;
      S_HEAD_CMP: state_d = (stat_i.op == OP_POP) ? S_SCAN_RD : S_EMIT;
      S_RUN_RD:   state_d = S_RUN_CMP;
      S_RUN_CMP:  state_d = stat_i.run_take ? S_SCAN_RD : S_EMIT;
      S_EMIT: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_EMIT_RUN: begin
        if (stat_i.out_free) state_d = S_RUN_RD;
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    cmd_o.rd_sel = RD_ZERO;
    cmd_o.wr_sel = WR_NEW;
    cmd_o.res    = RES_BAD;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.capture  = stat_i.in_valid;
      end
      S_CHECK: begin
        priority if (stat_i.op == OP_SCHEDULE || stat_i.op == OP_UNSCHEDULE) begin
          priority if (stat_i.id_bad) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res     = RES_BAD;
          end else if (stat_i.op == OP_SCHEDULE) begin
            cmd_o.set_res = stat_i.queued;
            cmd_o.res     = RES_IGN;
          end else begin
            cmd_o.set_res   = !stat_i.queued;
            cmd_o.res       = RES_IGN;
            cmd_o.scan_init = stat_i.queued;
          end
        end else if (stat_i.op == OP_POP || stat_i.op == OP_PEEK) begin
          cmd_o.set_res = stat_i.empty;
          cmd_o.res     = RES_EMPTY;
        end else if (stat_i.op == OP_RUNNABLES) begin
          cmd_o.set_res  = stat_i.run_bad;
          cmd_o.res      = RES_BAD;
          cmd_o.run_init = !stat_i.run_bad;
        end else begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = RES_BAD;
        end
      end
      S_CALC: cmd_o.calc = 1'b1;
      S_INS_RD: begin
        cmd_o.rd_sel = RD_DEC;
        if (stat_i.i_zero) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_sel   = WR_NEW;
          cmd_o.ins_done = 1'b1;
          cmd_o.set_res  = 1'b1;
          cmd_o.res      = RES_SCHED;
        end
      end
      S_INS_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.ins_move) begin
          cmd_o.wr_sel = WR_UP;
          cmd_o.i_dec  = 1'b1;
        end else begin
          cmd_o.wr_sel   = WR_NEW;
          cmd_o.ins_done = 1'b1;
          cmd_o.set_res  = 1'b1;
          cmd_o.res      = RES_SCHED;
        end
      end
      S_SCAN_RD: begin
        cmd_o.rd_sel = RD_J;
        if (stat_i.j_end) begin
          cmd_o.rm_done = 1'b1;
          cmd_o.set_res = 1'b1;
          cmd_o.res     = (stat_i.op == OP_RUNNABLES) ? RES_RUN_ITEM : RES_REMOVED;
        end
      end
      S_SCAN_CMP: begin
        cmd_o.j_inc      = 1'b1;
        cmd_o.wr_sel     = WR_DN;
        cmd_o.wr_en      = stat_i.found;
        cmd_o.mark_found = !stat_i.found && stat_i.id_match;
      end
      S_HEAD_RD: cmd_o.rd_sel = RD_ZERO;
      S_HEAD_CMP: begin
        if (stat_i.op == OP_POP) begin
          cmd_o.take_head = 1'b1;
        end else begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = RES_PEEK;
        end
      end
      S_RUN_RD: cmd_o.rd_sel = RD_ZERO;
      S_RUN_CMP: begin
        if (stat_i.run_take) begin
          cmd_o.take_head = 1'b1;
        end else begin
          cmd_o.set_res = 1'b1;
          cmd_o.res     = RES_CLOSE;
        end
      end
      S_EMIT: cmd_o.load_out = stat_i.out_free;
      S_EMIT_RUN: begin
        cmd_o.load_out = stat_i.out_free;
        cmd_o.n_inc    = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/ttdq_datapath.sv
// Datapath of the deadline queue: ordered entry memory, per-task state,
// deadline arithmetic, batch counters and the result register.
// Depends on ttdq_pkg, the channel interfaces and the assertion macros.
`include "timed_task_deadline_queue_assert.svh"

module ttdq_datapath import ttdq_pkg::*; #(
  parameter int MAX_TASKS = 64,
  parameter int MAX_BATCH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ttdq_in_if.sink   in_ch,
  ttdq_out_if.source out_ch,
  ttdq_cfg_if.sink  cfg_ch,
  input  cmd_t      cmd_i,
  output stat_t     stat_o
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int LW = $clog2(MAX_TASKS + 1);

  // Captured request.
  logic [OP_W-1:0]    op_q;
  logic [TASK_W-1:0]  id_q;
  logic [TIME_W-1:0]  now_q, ival_q, idly_q;
  logic               first_q, rep_q;
  logic [COUNT_W-1:0] mc_q;

  logic [JIT_W-1:0]   jitter_q;

  // Ordered list of queued tasks with their deadlines.
  ent_t               ent_mem [MAX_TASKS];
  ent_t               rdata_q;
  logic [IW-1:0]      raddr, waddr;
  ent_t               wdata;

  // Last start time per task, with a valid bit standing for the zero reset value.
  logic [TIME_W-1:0]  ls_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] ls_valid_q;
  logic [TIME_W-1:0]  ls_rd_q;
  logic               ls_vld_rd_q;

  logic [MAX_TASKS-1:0] queued_q;
  logic [LW-1:0]      len_q, i_q, j_q, i_m1, j_m1;
  logic               found_q;
  logic [TIME_W-1:0]  dl_q, thr_q, res_dl_q;
  logic [TASK_W-1:0]  res_task_q;
  logic [COUNT_W-1:0] n_q, limit_q;

  // Pending result fields.
  logic [TASK_W-1:0]  pr_task_q;
  logic               pr_has_q, pr_last_q;
  logic [OTIME_W-1:0] pr_time_q;
  logic [COUNT_W-1:0] pr_cnt_q;
  logic [ST_W-1:0]    pr_st_q;

  logic               ov_q, out_free;
  logic [IW-1:0]      idx, res_idx;
  logic               rep_path;
  logic [TIME_W-1:0]  base, addend;
  logic [TIME_W:0]    dl_sum, thr_sum;

  assign idx      = IW'(id_q);
  assign res_idx  = IW'(res_task_q);
  assign i_m1     = i_q - LW'(1);
  assign j_m1     = j_q - LW'(1);
  assign out_free = !ov_q || out_ch.ready;
  assign in_ch.ready  = cmd_i.in_ready;
  assign cfg_ch.ready = 1'b1;

  // Status toward the sequencer.
  always_comb begin
    stat_o.in_valid = in_ch.valid;
    stat_o.op       = op_q;
    stat_o.id_bad   = (32'(id_q) >= MAX_TASKS);
    stat_o.queued   = queued_q[idx];
    stat_o.empty    = (len_q == '0);
    stat_o.run_bad  = (now_q == '0) || (mc_q == '0);
    stat_o.i_zero   = (i_q == '0);
    stat_o.ins_move = (rdata_q.dl > dl_q);
    stat_o.j_end    = (j_q == len_q);
    stat_o.found    = found_q;
    stat_o.id_match = (rdata_q.tid == id_q);
    stat_o.run_take = (n_q < limit_q) && (len_q != '0) && (rdata_q.dl <= thr_q);
    stat_o.out_free = out_free;
  end

  // Request capture and jitter register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= in_ch.operation;
      id_q    <= in_ch.task_id;
      now_q   <= in_ch.now_time;
      first_q <= in_ch.is_first;
      rep_q   <= in_ch.do_repeat;
      ival_q  <= in_ch.interval;
      idly_q  <= in_ch.initial_delay;
      mc_q    <= in_ch.max_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jitter_q <= '0;
    end else if (cfg_ch.valid) begin
      jitter_q <= cfg_ch.sched_jitter;
    end
  end

  // Saturating deadline and due-threshold sums.
  assign rep_path = !first_q && rep_q;
  assign base     = rep_path ? (ls_vld_rd_q ? ls_rd_q : '0) : now_q;
  assign addend   = rep_path ? ival_q : idly_q;
  assign dl_sum   = {1'b0, base} + {1'b0, addend};
  assign thr_sum  = {1'b0, now_q} + (TIME_W + 1)'(jitter_q);

  // Entry memory address and data selection.
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_DEC:  raddr = i_m1[IW-1:0];
      RD_J:    raddr = j_q[IW-1:0];
      RD_ZERO: raddr = '0;
      default: raddr = '0;
    endcase
    unique case (cmd_i.wr_sel)
      WR_UP: begin
        waddr = i_q[IW-1:0];
        wdata = rdata_q;
      end
      WR_NEW: begin
        waddr = i_q[IW-1:0];
        wdata = '{tid: id_q, dl: dl_q};
      end
      WR_DN: begin
        waddr = j_m1[IW-1:0];
        wdata = rdata_q;
      end
      default: begin
        waddr = '0;
        wdata = rdata_q;
      end
    endcase
  end

  // Entry memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) ent_mem[waddr] <= wdata;
    rdata_q <= ent_mem[raddr];
  end

  // Last start memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc && !rep_path) ls_mem[idx] <= now_q;
    ls_rd_q     <= ls_mem[idx];
    ls_vld_rd_q <= ls_valid_q[idx];
  end

  // Per-task flags and list length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ls_valid_q <= '0;
      queued_q   <= '0;
      len_q      <= '0;
    end else begin
      if (cmd_i.calc && !rep_path) ls_valid_q[idx] <= 1'b1;
      if (cmd_i.ins_done) begin
        queued_q[idx] <= 1'b1;
        len_q         <= len_q + LW'(1);
      end else if (cmd_i.rm_done) begin
        queued_q[res_idx] <= 1'b0;
        len_q             <= len_q - LW'(1);
      end
    end
  end

  // Walk counters and batch bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q     <= '0;
      j_q     <= '0;
      found_q <= 1'b0;
      n_q     <= '0;
      limit_q <= '0;
    end else begin
      if (cmd_i.calc) i_q <= len_q;
      else if (cmd_i.i_dec) i_q <= i_m1;
      if (cmd_i.scan_init) begin
        j_q     <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.take_head) begin
        j_q     <= LW'(1);
        found_q <= 1'b1;
      end else begin
        if (cmd_i.mark_found) found_q <= 1'b1;
        if (cmd_i.j_inc) j_q <= j_q + LW'(1);
      end
      if (cmd_i.run_init) begin
        n_q     <= '0;
        limit_q <= ({1'b0, mc_q} > 6'(MAX_BATCH)) ? COUNT_W'(MAX_BATCH) : mc_q;
      end else if (cmd_i.n_inc) begin
        n_q <= n_q + COUNT_W'(1);
      end
    end
  end

  // Deadline, threshold and removed-entry registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) dl_q <= dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
    if (cmd_i.run_init) thr_q <= thr_sum[TIME_W] ? TIME_MAX : thr_sum[TIME_W-1:0];
    if (cmd_i.take_head || cmd_i.mark_found) begin
      res_task_q <= rdata_q.tid;
      res_dl_q   <= rdata_q.dl;
    end
  end

  // Pending result formatting.
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_res) begin
      pr_task_q <= '0;
      pr_has_q  <= 1'b0;
      pr_time_q <= TIME_NONE;
      pr_cnt_q  <= '0;
      pr_st_q   <= ST_OK;
      pr_last_q <= 1'b1;
      unique case (cmd_i.res)
        RES_BAD:   pr_st_q <= ST_BAD;
        RES_IGN: begin
          pr_task_q <= id_q;
          pr_has_q  <= 1'b1;
          pr_st_q   <= ST_IGNORED;
        end
        RES_EMPTY: pr_st_q <= ST_EMPTY;
        RES_SCHED: begin
          pr_task_q <= id_q;
          pr_has_q  <= 1'b1;
          pr_time_q <= {1'b0, dl_q};
        end
        RES_REMOVED, RES_RUN_ITEM: begin
          pr_task_q <= res_task_q;
          pr_has_q  <= 1'b1;
          pr_time_q <= {1'b0, res_dl_q};
          pr_last_q <= (cmd_i.res == RES_REMOVED);
        end
        RES_PEEK: begin
          pr_task_q <= rdata_q.tid;
          pr_has_q  <= 1'b1;
          pr_time_q <= {1'b0, rdata_q.dl};
        end
        RES_CLOSE: begin
          pr_time_q <= (len_q != '0) ? {1'b0, rdata_q.dl} : TIME_NONE;
          pr_cnt_q  <= n_q;
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      ov_q <= 1'b1;
    end else if (out_ch.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_ch.result_task <= pr_task_q;
      out_ch.has_task    <= pr_has_q;
      out_ch.time_value  <= pr_time_q;
      out_ch.due_count   <= pr_cnt_q;
      out_ch.status      <= pr_st_q;
      out_ch.last        <= pr_last_q;
    end
  end

  assign out_ch.valid = ov_q;

  // The queued flags and the list length describe the same set.
  `TTDQ_ASSERT(a_len_matches_flags, 1'b1, $countones(queued_q) == 32'(len_q))
  `TTDQ_ASSERT(a_len_bounded, 1'b1, 32'(len_q) <= MAX_TASKS)
  `TTDQ_ASSERT(a_batch_bounded, 1'b1, n_q <= limit_q)
  `TTDQ_ASSERT_NEXT(a_load_needs_room, cmd_i.load_out, ov_q)

endmodule

// File: rtl/timed_task_deadline_queue.sv
// Deadline-ordered task queue. Requests are taken one at a time; results leave
// through a registered output beat. Schedule walks the ordered entry memory
// from the tail, moving up each entry whose deadline lies past the new one;
// unschedule and pop walk every queued entry, moving down those behind the
// removed one; peek reads the head only; get-runnables walks the queued
// entries once for each task handed out, then sends a closing beat. The walks
// follow from the entry memory with its single registered read port. A result
// beat that the sink does not take holds the block until it is taken.
// Depends on ttdq_pkg, the channel interfaces, ttdq_ctrl and ttdq_datapath.
module timed_task_deadline_queue import ttdq_pkg::*; #(
  parameter int MAX_TASKS = 64,
  parameter int MAX_BATCH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ttdq_in_if.sink    in_ch,
  ttdq_out_if.source out_ch,
  ttdq_cfg_if.sink   cfg_ch
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  ttdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Storage and arithmetic.
  ttdq_datapath #(
    .MAX_TASKS (MAX_TASKS),
    .MAX_BATCH (MAX_BATCH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

// File: verif/tb.sv
// Testbench for timed_task_deadline_queue: directed table, then random phases.
// Depends on ttdq_pkg, ttdq_in_if, ttdq_out_if, ttdq_cfg_if and the queue RTL.
`timescale 1ns / 100ps

module tb;
  import ttdq_pkg::*;

  localparam int NUM_TASKS = 64;
  localparam int BATCH_MAX = 16;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam int PHASE_ITEMS = 52;
  localparam int IDLE_PCT = 38;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [TASK_W-1:0]  id;
    logic [TIME_W-1:0]  now;
    logic               first;
    logic               rep;
    logic [TIME_W-1:0]  ival;
    logic [TIME_W-1:0]  idly;
    logic [COUNT_W-1:0] mc;
  } request_t;

  typedef struct packed {
    logic [TASK_W-1:0]  tid;
    logic               has;
    logic [OTIME_W-1:0] tv;
    logic [COUNT_W-1:0] cnt;
    logic [ST_W-1:0]    st;
    logic               lst;
  } answer_t;

  typedef struct packed {
    request_t req;
    logic     fixed;
    answer_t  ans;
  } table_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ttdq_in_if  in_ch();
  ttdq_out_if out_ch();
  ttdq_cfg_if cfg_ch();

  timed_task_deadline_queue #(.MAX_TASKS(NUM_TASKS), .MAX_BATCH(BATCH_MAX)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Shadow copy of the queue contents and the jitter register.
  logic [TIME_W-1:0] due_time [NUM_TASKS];
  logic [TIME_W-1:0] start_time [NUM_TASKS];
  bit                in_queue [NUM_TASKS];
  int                deadline_order[$];
  logic [JIT_W-1:0]  jitter_shadow;

  answer_t    pending_answers[$];
  table_row_t directed_rows[$];
  bit         no_idle = 1'b0;
  int         mismatches = 0;
  int         answers_seen = 0;
  int         requests_sent = 0;
  int         tasks_handed_out = 0;

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  function automatic request_t mk_req(logic [OP_W-1:0] op, logic [TASK_W-1:0] id,
      logic [TIME_W-1:0] now, logic first, logic rep, logic [TIME_W-1:0] ival,
      logic [TIME_W-1:0] idly, logic [COUNT_W-1:0] mc);
    request_t r;
    r = '{op, id, now, first, rep, ival, idly, mc};
    return r;
  endfunction

  function automatic answer_t mk_ans(logic [TASK_W-1:0] tid, logic has,
      logic [OTIME_W-1:0] tv, logic [COUNT_W-1:0] cnt, logic [ST_W-1:0] st, logic lst);
    answer_t a;
    a = '{tid, has, tv, cnt, st, lst};
    return a;
  endfunction

  // Works out the result beats of one accepted request and updates the shadow queue.
  task automatic queue_predict(request_t rq);
    int p;
    int n;
    int lim;
    int h;
    logic [TIME_W-1:0] thr;
    case (rq.op)
      OP_SCHEDULE: begin
        if (in_queue[rq.id]) begin
          pending_answers.push_back(mk_ans(rq.id, 1'b1, TIME_NONE, '0, ST_IGNORED, 1'b1));
        end else begin
          if (!rq.first && rq.rep) begin
            due_time[rq.id] = sat_sum(start_time[rq.id], rq.ival);
          end else begin
            start_time[rq.id] = rq.now;
            due_time[rq.id] = sat_sum(rq.now, rq.idly);
          end
          // Equal deadlines go behind the ones already queued.
          p = 0;
          while (p < deadline_order.size() && due_time[deadline_order[p]] <= due_time[rq.id])
            p++;
          deadline_order.insert(p, rq.id);
          in_queue[rq.id] = 1'b1;
          pending_answers.push_back(mk_ans(rq.id, 1'b1, {1'b0, due_time[rq.id]}, '0,
                                           ST_OK, 1'b1));
        end
      end
      OP_UNSCHEDULE: begin
        if (!in_queue[rq.id]) begin
          pending_answers.push_back(mk_ans(rq.id, 1'b1, TIME_NONE, '0, ST_IGNORED, 1'b1));
        end else begin
          for (p = 0; p < deadline_order.size(); p++)
            if (deadline_order[p] == rq.id) break;
          deadline_order.delete(p);
          in_queue[rq.id] = 1'b0;
          pending_answers.push_back(mk_ans(rq.id, 1'b1, {1'b0, due_time[rq.id]}, '0,
                                           ST_OK, 1'b1));
        end
      end
      OP_POP, OP_PEEK: begin
        if (deadline_order.size() == 0) begin
          pending_answers.push_back(mk_ans('0, 1'b0, TIME_NONE, '0, ST_EMPTY, 1'b1));
        end else begin
          h = deadline_order[0];
          if (rq.op == OP_POP) begin
            void'(deadline_order.pop_front());
            in_queue[h] = 1'b0;
          end
          pending_answers.push_back(mk_ans(TASK_W'(h), 1'b1, {1'b0, due_time[h]}, '0,
                                           ST_OK, 1'b1));
        end
      end
      OP_RUNNABLES: begin
        if (rq.now == '0 || rq.mc == '0) begin
          pending_answers.push_back(mk_ans('0, 1'b0, TIME_NONE, '0, ST_BAD, 1'b1));
        end else begin
          lim = (rq.mc > BATCH_MAX) ? BATCH_MAX : int'(rq.mc);
          thr = sat_sum(rq.now, {{(TIME_W-JIT_W){1'b0}}, jitter_shadow});
          n = 0;
          while (n < lim && deadline_order.size() > 0 && due_time[deadline_order[0]] <= thr) begin
            h = deadline_order.pop_front();
            in_queue[h] = 1'b0;
            pending_answers.push_back(mk_ans(TASK_W'(h), 1'b1, {1'b0, due_time[h]}, '0,
                                             ST_OK, 1'b0));
            n++;
          end
          tasks_handed_out += n;
          pending_answers.push_back(mk_ans('0, 1'b0,
              deadline_order.size() > 0 ? {1'b0, due_time[deadline_order[0]]} : TIME_NONE,
              COUNT_W'(n), ST_OK, 1'b1));
        end
      end
      default: begin
        pending_answers.push_back(mk_ans('0, 1'b0, TIME_NONE, '0, ST_BAD, 1'b1));
      end
    endcase
  endtask

  // Presents one request beat, with random idle cycles before it.
  task automatic send_request(table_row_t row);
    bit hs;
    @(posedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= row.req.op;
    in_ch.task_id       <= row.req.id;
    in_ch.now_time      <= row.req.now;
    in_ch.is_first      <= row.req.first;
    in_ch.do_repeat     <= row.req.rep;
    in_ch.interval      <= row.req.ival;
    in_ch.initial_delay <= row.req.idly;
    in_ch.max_count     <= row.req.mc;
    do begin
      @(negedge clk_i);
      hs = in_ch.ready;
      @(posedge clk_i);
    end while (!hs);
    requests_sent++;
    queue_predict(row.req);
    if (row.fixed) begin
      void'(pending_answers.pop_back());
      pending_answers.push_back(row.ans);
    end
  endtask

  // Lets the queue drain, then writes the jitter register.
  task automatic write_jitter(logic [JIT_W-1:0] value);
    bit hs;
    in_ch.valid <= 1'b0;
    while (pending_answers.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.sched_jitter <= value;
    do begin
      @(negedge clk_i);
      hs = cfg_ch.ready;
      @(posedge clk_i);
    end while (!hs);
    cfg_ch.valid  <= 1'b0;
    jitter_shadow = value;
  endtask

  // Builds one random request, mostly small times so that tasks fall due.
  function automatic request_t random_request(ref logic [TIME_W-1:0] clock_now);
    request_t r;
    int pick;
    bit wide;
    clock_now = clock_now + TIME_W'($urandom_range(0, 40));
    wide = ($urandom_range(0, 99) < 15);
    pick = $urandom_range(0, 99);
    r.op = (pick < 45) ? OP_SCHEDULE : (pick < 57) ? OP_UNSCHEDULE : (pick < 67) ? OP_POP :
           (pick < 87) ? OP_RUNNABLES : (pick < 95) ? OP_PEEK :
           3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    r.id    = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 15)) : 6'($urandom);
    r.first = 1'($urandom);
    r.rep   = 1'($urandom);
    r.mc    = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(1, 16)) : 5'($urandom);
    if (wide) begin
      r.now  = TIME_W'({$urandom, $urandom});
      r.ival = TIME_W'({$urandom, $urandom});
      r.idly = TIME_W'({$urandom, $urandom});
    end else begin
      r.now  = clock_now;
      r.ival = TIME_W'($urandom_range(0, 400));
      r.idly = TIME_W'($urandom_range(0, 400));
    end
    if (r.op == OP_RUNNABLES && $urandom_range(0, 99) < 3) r.now = '0;
    return r;
  endfunction

  // Result side: random back-pressure, compare each beat with the oldest expectation.
  initial begin
    answer_t got;
    answer_t want;
    bit hs;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      hs  = out_ch.valid && out_ch.ready;
      got = mk_ans(out_ch.result_task, out_ch.has_task, out_ch.time_value,
                   out_ch.due_count, out_ch.status, out_ch.last);
      @(posedge clk_i);
      if (hs) begin
        answers_seen++;
        if (pending_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %p", got);
        end else begin
          want = pending_answers.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected task %0d has %0b time %0d count %0d",
                       want.tid, want.has, $signed(want.tv), want.cnt);
              $display("  st %0d last %0b, got task %0d has %0b time %0d count %0d",
                       want.st, want.lst, got.tid, got.has, $signed(got.tv), got.cnt);
              $display("  st %0d last %0b", got.st, got.lst);
            end
          end
        end
      end
      out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Stimulus: reset, directed table, then random phases at several jitter settings.
  initial begin
    logic [TIME_W-1:0] clock_now;
    logic [JIT_W-1:0] phase_jitter [4];
    table_row_t row;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_PEEK;
    in_ch.task_id = '0;
    in_ch.now_time = '0;
    in_ch.is_first = 1'b0;
    in_ch.do_repeat = 1'b0;
    in_ch.interval = '0;
    in_ch.initial_delay = '0;
    in_ch.max_count = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.sched_jitter = '0;
    jitter_shadow = '0;
    foreach (due_time[i]) begin
      due_time[i] = '0;
      start_time[i] = '0;
      in_queue[i] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_jitter('0);

    // Directed rows; fixed ones carry the result typed in.
    directed_rows.push_back('{mk_req(OP_POP, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_ans(0, 0, TIME_NONE, 0, ST_EMPTY, 1)});
    directed_rows.push_back('{mk_req(OP_PEEK, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_ans(0, 0, TIME_NONE, 0, ST_EMPTY, 1)});
    directed_rows.push_back('{mk_req(OP_RUNNABLES, 0, 0, 0, 0, 0, 0, 5), 1'b1,
                              mk_ans(0, 0, TIME_NONE, 0, ST_BAD, 1)});
    directed_rows.push_back('{mk_req(OP_RUNNABLES, 0, 100, 0, 0, 0, 0, 0), 1'b1,
                              mk_ans(0, 0, TIME_NONE, 0, ST_BAD, 1)});
    directed_rows.push_back('{mk_req(OP_UNUSED_LO, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_ans(0, 0, TIME_NONE, 0, ST_BAD, 1)});
    directed_rows.push_back('{mk_req(OP_UNUSED_HI, 63, TIME_MAX, 1, 1, TIME_MAX, TIME_MAX, 31),
                              1'b1, mk_ans(0, 0, TIME_NONE, 0, ST_BAD, 1)});
    directed_rows.push_back('{mk_req(OP_UNSCHEDULE, 9, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_ans(9, 1, TIME_NONE, 0, ST_IGNORED, 1)});
    directed_rows.push_back('{mk_req(OP_SCHEDULE, 0, 100, 1, 0, 0, 50, 0), 1'b1,
                              mk_ans(0, 1, 150, 0, ST_OK, 1)});
    // The deadline sum at the top of the range saturates.
    directed_rows.push_back('{mk_req(OP_SCHEDULE, 63, TIME_MAX, 1, 0, 0, TIME_MAX, 0), 1'b1,
                              mk_ans(63, 1, {1'b0, TIME_MAX}, 0, ST_OK, 1)});
    directed_rows.push_back('{mk_req(OP_SCHEDULE, 0, 7, 1, 0, 0, 7, 0), 1'b1,
                              mk_ans(0, 1, TIME_NONE, 0, ST_IGNORED, 1)});
    // Equal deadline queues behind task 0; a repeat from a zero start time.
    directed_rows.push_back('{mk_req(OP_SCHEDULE, 5, 120, 1, 0, 0, 30, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_SCHEDULE, 6, 0, 0, 1, 140, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_PEEK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_RUNNABLES, 0, 145, 0, 0, 0, 0, 31), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_RUNNABLES, 0, 150, 0, 0, 0, 0, 1), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_UNSCHEDULE, 5, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_SCHEDULE, 7, 0, 0, 1, TIME_MAX, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_SCHEDULE, 8, 10, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_POP, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_UNSCHEDULE, 63, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_UNSCHEDULE, 7, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_SCHEDULE, 1, 2000, 1, 1, 9, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_SCHEDULE, 2, 0, 0, 1, 5, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_RUNNABLES, 0, TIME_MAX, 0, 0, 0, 0, 16), 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_RUNNABLES, 0, TIME_MAX, 0, 0, 0, 0, 16), 1'b0, '0});
    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // Random phases: all due, exact, small tolerance, full random tolerance.
    phase_jitter[0] = '1;
    phase_jitter[1] = '0;
    phase_jitter[2] = $urandom_range(1, 500);
    phase_jitter[3] = $urandom;
    clock_now = 1000;
    for (int ph = 0; ph < 4; ph++) begin
      write_jitter(phase_jitter[ph]);
      no_idle = (ph == 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        row.req   = random_request(clock_now);
        row.fixed = 1'b0;
        row.ans   = '0;
        send_request(row);
      end
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending_answers.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d result beats, %0d tasks handed out as due.",
             requests_sent, answers_seen, tasks_handed_out);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding.", pending_answers.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
